FILE: rtl/atma_pkg.sv
package atma_pkg;

    localparam int HISTORY_DEF = 50;
    localparam int CODE_W      = 10;
    localparam int TEMP_W      = 8;
    localparam int PROD_W      = 20;
    localparam int SCALE_W     = PROD_W - CODE_W;
    localparam int SCALE       = 900;
    localparam int ROUND       = 512;
    localparam int OFFSET_F    = 58;
    localparam int TEMP_MAX    = 255;

    typedef struct packed {
        logic accept;
        logic update;
        logic div_step;
        logic load_out;
    } atma_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } atma_sts_t;

    function automatic logic [TEMP_W-1:0] to_fahrenheit(input logic [CODE_W-1:0] code);
        logic [PROD_W-1:0]  prod;
        logic [SCALE_W-1:0] scaled;
        logic [SCALE_W-1:0] diff;
        logic [TEMP_W-1:0]  res;
        prod   = PROD_W'(code) * PROD_W'(SCALE) + PROD_W'(ROUND);
        scaled = prod[PROD_W-1:CODE_W];
        diff   = scaled - SCALE_W'(OFFSET_F);
        if (scaled < SCALE_W'(OFFSET_F))
        begin
            res = '0;
        end
        else if (diff > SCALE_W'(TEMP_MAX))
        begin
            res = TEMP_W'(TEMP_MAX);
        end
        else
        begin
            res = diff[TEMP_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/adc_temperature_moving_average_top.sv
// channel   signals                              handshake
// in        adc_code[9:0]                        in_valid / in_ready
// out       avg_temp_f[7:0], history_empty       out_valid / out_ready
//
// An accepted item passes through the ring update and the serial divider, one
// quotient bit a cycle, into the result register; the next item is taken only
// after that result is loaded, so one item is in flight at a time.
// Reset clears the ring valid bits, slot, sum and count at once; no sweep.
// A finished result waits in the output register while the next item is taken;
// the divider result holds until that register is free.
module adc_temperature_moving_average_top #(
    parameter int HISTORY = atma_pkg::HISTORY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [atma_pkg::CODE_W-1:0] adc_code,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [atma_pkg::TEMP_W-1:0] avg_temp_f,
    output logic                        history_empty
);

    import atma_pkg::*;

    atma_cmd_t cmd;
    atma_sts_t sts;

    atma_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    atma_dp #(
        .HISTORY(HISTORY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .adc_code     (adc_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .avg_temp_f   (avg_temp_f),
        .history_empty(history_empty)
    );

    a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> cmd.update)
        else $error("accepted item not followed by ring update");

    a_busy_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> !in_ready)
        else $error("input ready during division");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid)
        else $error("result load did not raise out_valid");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("result overwritten before being taken");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && history_empty) |-> (avg_temp_f == '0))
        else $error("empty history with nonzero mean");

endmodule

FILE: rtl/atma_ram.sv
module atma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 50,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/atma_ctrl.sv
module atma_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  atma_pkg::atma_sts_t sts,
    output atma_pkg::atma_cmd_t cmd
);

    import atma_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_DIV    = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.update   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/atma_dp.sv
module atma_dp #(
    parameter int HISTORY = atma_pkg::HISTORY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  atma_pkg::atma_cmd_t                cmd,
    output atma_pkg::atma_sts_t                sts,
    input  logic [atma_pkg::CODE_W-1:0]        adc_code,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [atma_pkg::TEMP_W-1:0]        avg_temp_f,
    output logic                               history_empty
);

    import atma_pkg::*;

    localparam int SLOT_W = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int CNT_W  = $clog2(HISTORY + 1);
    localparam int SUM_W  = $clog2(HISTORY * TEMP_MAX + 1);
    localparam int STEP_W = $clog2(SUM_W);

    logic [TEMP_W-1:0]  reading_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [HISTORY-1:0] valid_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   rem_reg;
    logic [SUM_W-1:0]   quo_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               out_valid_reg;
    logic [TEMP_W-1:0]  avg_reg;
    logic               empty_reg;

    logic [TEMP_W-1:0]  rd_data;
    logic [TEMP_W-1:0]  old_val;
    logic               old_nz;
    logic               new_nz;
    logic [CNT_W:0]     trial;
    logic               quo_bit;

    atma_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (HISTORY),
        .ADDR_W(SLOT_W)
    ) u_ring (
        .clk  (clk),
        .we   (cmd.update),
        .waddr(slot_reg),
        .wdata(reading_reg),
        .re   (cmd.accept),
        .raddr(slot_reg),
        .rdata(rd_data)
    );

    // unwritten entries read as zero
    assign old_val    = valid_reg[slot_reg] ? rd_data : '0;
    assign old_nz     = (old_val != '0);
    assign new_nz     = (reading_reg != '0);
    assign sum_next   = sum_reg - SUM_W'(old_val) + SUM_W'(reading_reg);
    assign count_next = count_reg - CNT_W'(old_nz) + CNT_W'(new_nz);

    assign trial   = {rem_reg, quo_reg[SUM_W-1]};
    assign quo_bit = (trial >= {1'b0, count_reg});

    assign sts.div_last = (step_reg == '0);
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            reading_reg <= to_fahrenheit(adc_code);
        end
        if (cmd.update)
        begin
            rem_reg  <= '0;
            quo_reg  <= sum_next;
            step_reg <= STEP_W'(SUM_W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= quo_bit ? CNT_W'(trial - {1'b0, count_reg}) : trial[CNT_W-1:0];
            quo_reg  <= {quo_reg[SUM_W-2:0], quo_bit};
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.load_out)
        begin
            avg_reg   <= (count_reg == '0) ? '0 : quo_reg[TEMP_W-1:0];
            empty_reg <= (count_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            valid_reg     <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                valid_reg[slot_reg] <= 1'b1;
                sum_reg             <= sum_next;
                count_reg           <= count_next;
                slot_reg            <= (slot_reg == SLOT_W'(HISTORY - 1)) ? '0 : slot_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign avg_temp_f    = avg_reg;
    assign history_empty = empty_reg;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

class temp_average_board;

    typedef struct packed {
        logic [atma_pkg::TEMP_W-1:0] avg;
        logic                        empty;
    } avg_result_t;

    logic [atma_pkg::TEMP_W-1:0] ring_f[];
    int unsigned                 slot;
    int unsigned                 sum_f;
    int unsigned                 nonzero;
    int unsigned                 depth;
    avg_result_t                 avg_q[$];
    int                          errors;

    function new(int unsigned history);
        depth   = history;
        ring_f  = new[history];
        foreach (ring_f[i])
        begin
            ring_f[i] = '0;
        end
        slot    = 0;
        sum_f   = 0;
        nonzero = 0;
        errors  = 0;
    endfunction

    function logic [atma_pkg::TEMP_W-1:0] code_to_degrees(logic [atma_pkg::CODE_W-1:0] code);
        int unsigned scaled;
        scaled = (int'(code) * 900 + 512) >> 10;
        if (scaled < 58)
        begin
            return '0;
        end
        scaled = scaled - 58;
        return (scaled > 255) ? 8'd255 : scaled[7:0];
    endfunction

    function void note_code(logic [atma_pkg::CODE_W-1:0] code);
        logic [atma_pkg::TEMP_W-1:0] reading;
        avg_result_t                 res;
        reading = code_to_degrees(code);
        if (ring_f[slot] != 0)
        begin
            sum_f   = sum_f - ring_f[slot];
            nonzero = nonzero - 1;
        end
        if (reading != 0)
        begin
            sum_f   = sum_f + reading;
            nonzero = nonzero + 1;
        end
        ring_f[slot] = reading;
        slot = (slot >= depth - 1) ? 0 : slot + 1;
        if (nonzero == 0)
        begin
            res.avg   = '0;
            res.empty = 1'b1;
        end
        else
        begin
            res.avg   = 8'((sum_f / nonzero) & 32'hFF);
            res.empty = 1'b0;
        end
        avg_q.push_back(res);
    endfunction

    function void check_result(logic [atma_pkg::TEMP_W-1:0] avg, logic empty);
        avg_result_t want;
        if (avg_q.size() == 0)
        begin
            $display("%0t: unexpected result avg_temp_f=%0d history_empty=%0b",
                     $time, avg, empty);
            errors++;
            return;
        end
        want = avg_q.pop_front();
        if (avg !== want.avg)
        begin
            $display("%0t: avg_temp_f expected %0d actual %0d", $time, want.avg, avg);
            errors++;
        end
        if (empty !== want.empty)
        begin
            $display("%0t: history_empty expected %0b actual %0b", $time, want.empty, empty);
            errors++;
        end
    endfunction

    function int pending();
        return avg_q.size();
    endfunction

endclass

module tb;

    localparam int HISTORY      = atma_pkg::HISTORY_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1830;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [atma_pkg::CODE_W-1:0] adc_code;
    logic                        out_valid;
    logic                        out_ready;
    logic [atma_pkg::TEMP_W-1:0] avg_temp_f;
    logic                        history_empty;

    bit                          calm;
    int                          sent;
    temp_average_board           board = new(HISTORY);

    adc_temperature_moving_average_top #(
        .HISTORY(HISTORY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .adc_code(adc_code),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .avg_temp_f(avg_temp_f),
        .history_empty(history_empty)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            board.note_code(adc_code);
        end
        if (rst_n && out_valid && out_ready)
        begin
            board.check_result(avg_temp_f, history_empty);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    task automatic send_code(input logic [atma_pkg::CODE_W-1:0] code);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        adc_code <= code;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_run(input int count, input int lo, input int hi);
        for (int i = 0; i < count; i++)
        begin
            send_code(atma_pkg::CODE_W'($urandom_range(lo, hi)));
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int  kind;
        bit  paused;
        logic [atma_pkg::CODE_W-1:0] directed_codes[$];
        in_valid = 1'b0;
        adc_code = '0;
        rst_n    = 1'b0;
        calm     = 1'b0;
        sent     = 0;
        paused   = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // cold, zero boundary, first nonzero, hot boundary, bit patterns
        directed_codes = '{10'd0, 10'd66, 10'd67, 10'd1023, 10'd357, 10'd356, 10'd0,
                           10'd65, 10'd1, 10'd512, 10'h2AA, 10'h155, 10'd200, 10'd300,
                           10'd1023, 10'd68, 10'd150, 10'd250, 10'd340, 10'd100};
        foreach (directed_codes[i])
        begin
            send_code(directed_codes[i]);
        end

        while (sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            case (kind)
                0: send_run($urandom_range(HISTORY + 2, HISTORY + 10), 0, 66);
                1: send_run($urandom_range(5, 20), 356, 1023);
                2: send_run(20, 0, 1023);
                3: send_run(HISTORY + 10, 67, 1023);
                default: send_run($urandom_range(10, 40), 90, 340);
            endcase
            if (!paused && sent > RANDOM_ITEMS / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (board.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: adc_temperature_moving_average_top.f
rtl/atma_pkg.sv
rtl/atma_ram.sv
rtl/atma_ctrl.sv
rtl/atma_dp.sv
rtl/adc_temperature_moving_average_top.sv
verif/tb.sv
